FILE: design/bsc_pkg.sv
// Shared types, constants and arithmetic helpers for the barometric compensation block.
package bsc_pkg;

  typedef enum logic [1:0] {
    CFG_COEF_A,
    CFG_COEF_B,
    CFG_COEF_C,
    CFG_OSS
  } cfg_index_t;

  localparam int unsigned DIV_STAGES = 32;

  localparam logic [31:0] T_ROUND  = 32'd8;
  localparam logic [31:0] T_OFFSET = 32'd4000;
  localparam logic [31:0] B4_BIAS  = 32'd32768;
  localparam logic [31:0] B7_SCALE = 32'd50000;
  localparam logic [31:0] P_C1     = 32'd3038;
  localparam logic [31:0] P_C2     = 32'hFFFF_E343;
  localparam logic [31:0] P_C3     = 32'd3791;

  typedef struct packed {
    logic [31:0] ac1;
    logic [31:0] ac2;
    logic [31:0] ac3;
    logic [31:0] ac4;
    logic [31:0] ac5;
    logic [31:0] ac6;
    logic [31:0] b1;
    logic [31:0] b2;
    logic [31:0] mc;
    logic [31:0] md;
    logic [1:0]  oss;
  } coef_t;

  typedef struct packed {
    logic [31:0] diff;
    logic [18:0] up;
  } front_item_t;

  typedef struct packed {
    logic [31:0] x1;
    logic [18:0] up;
    logic        neg;
    logic        err;
  } ctx_a_t;

  typedef struct packed {
    logic [31:0] t;
    logic        sel;
    logic        err;
  } ctx_b_t;

  function automatic logic [31:0] asr32(input logic [31:0] a, input int unsigned n);
    return 32'($signed(a) >>> n);
  endfunction

  function automatic logic [31:0] sext16(input logic [15:0] a);
    return {{16{a[15]}}, a};
  endfunction

  function automatic logic [31:0] mul32(input logic [31:0] a, input logic [31:0] b);
    logic [63:0] p;
    p = a * b;
    return p[31:0];
  endfunction

endpackage

FILE: design/bsc_front.sv
// Front end: takes input items, forms the first temperature term and queues them.
module bsc_front (
  input  logic                 clk,
  input  logic                 rst,
  input  bsc_pkg::coef_t       coef,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [15:0]          raw_temperature,
  input  logic [18:0]          raw_pressure,
  output logic                 q_valid,
  input  logic                 q_take,
  output bsc_pkg::front_item_t q_item
);

  bsc_pkg::front_item_t slots [0:1];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  bsc_pkg::front_item_t push_item;

  assign in_ready = (count != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (count != 2'd0);
  assign q_item   = slots[rd_ptr];

  always_comb begin
    push_item.diff = {16'd0, raw_temperature} - coef.ac6;
    push_item.up   = raw_pressure;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (q_take) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(q_take);
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_item;
  end

endmodule

FILE: design/bsc_div.sv
// Pipelined unsigned 32-bit divider, one quotient bit per stage.
module bsc_div (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic [31:0] quotient
);

  logic [31:0] rem [1:bsc_pkg::DIV_STAGES-1];
  logic [31:0] quo [1:bsc_pkg::DIV_STAGES];
  logic [31:0] dvs [1:bsc_pkg::DIV_STAGES-1];

  for (genvar i = 0; i < bsc_pkg::DIV_STAGES; i++) begin : g_stage
    logic [31:0] r_in;
    logic [31:0] q_in;
    logic [31:0] d_in;
    logic [32:0] trial;
    logic        ge;
    if (i == 0) begin : g_first
      assign r_in = '0;
      assign q_in = dividend;
      assign d_in = divisor;
    end else begin : g_rest
      assign r_in = rem[i];
      assign q_in = quo[i];
      assign d_in = dvs[i];
    end
    assign trial = {r_in, q_in[31]};
    assign ge    = (trial >= {1'b0, d_in});
    always_ff @(posedge clk) begin
      if (en) quo[i+1] <= {q_in[30:0], ge};
    end
    // The last stage only needs its quotient.
    if (i < bsc_pkg::DIV_STAGES - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem[i+1] <= ge ? 32'(trial - {1'b0, d_in}) : trial[31:0];
          dvs[i+1] <= d_in;
        end
      end
    end
  end

  assign quotient = quo[bsc_pkg::DIV_STAGES];

endmodule

FILE: design/bsc_back.sv
// Back end: stalling arithmetic pipeline with two dividers and the output register.
module bsc_back (
  input  logic                 clk,
  input  logic                 rst,
  input  bsc_pkg::coef_t       coef,
  input  logic                 q_valid,
  output logic                 q_take,
  input  bsc_pkg::front_item_t q_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [31:0]          temperature,
  output logic [31:0]          pressure,
  output logic                 divide_error
);

  localparam int unsigned N = bsc_pkg::DIV_STAGES;

  logic en;
  assign en     = !out_valid || out_ready;
  assign q_take = en && q_valid;

  // valid bits
  logic          v1, v2, v3, v4, v5, v6, v7, v8, v9, v11, v12, v13;
  logic [N-1:0]  va;
  logic [N-1:0]  vb;

  // stage payloads
  logic [31:0] s1_m;   logic [18:0] s1_up;
  logic [31:0] s2_x1, s2_den, s2_num; logic [18:0] s2_up;
  logic [31:0] s3_b5;  bsc_pkg::ctx_a_t s3_ctx;
  logic [31:0] s4_t, s4_b6; logic [18:0] s4_up; logic s4_err;
  logic [31:0] s5_sq, s5_m2, s5_m3, s5_t; logic [18:0] s5_up; logic s5_err;
  logic [31:0] s6_p1, s6_p2, s6_x2, s6_x1, s6_t; logic [18:0] s6_up; logic s6_err;
  logic [31:0] s7_b3, s7_x3, s7_t; logic [18:0] s7_up; logic s7_err;
  logic [31:0] s8_b4m, s8_bu, s8_t; logic s8_err;
  logic [31:0] s9_b4, s9_b7, s9_t; logic s9_err;
  logic [31:0] s11_p; bsc_pkg::ctx_b_t s11_ctx;
  logic [31:0] s12_p, s12_m1, s12_m2, s12_t; logic s12_err;
  logic [31:0] s13_p, s13_m3, s13_x2, s13_t; logic s13_err;

  bsc_pkg::ctx_a_t ctx_a [0:N-1];
  bsc_pkg::ctx_b_t ctx_b [0:N-1];

  // temperature divider operands
  logic [31:0] num_mag, den_mag, qa;
  bsc_pkg::ctx_a_t ctx_a_in;
  always_comb begin
    num_mag      = s2_num[31] ? 32'(-s2_num) : s2_num;
    den_mag      = s2_den[31] ? 32'(-s2_den) : s2_den;
    ctx_a_in.x1  = s2_x1;
    ctx_a_in.up  = s2_up;
    ctx_a_in.neg = s2_num[31] ^ s2_den[31];
    ctx_a_in.err = (s2_den == 32'd0);
  end

  bsc_div u_div_t (
    .clk      (clk),
    .en       (en),
    .dividend (num_mag),
    .divisor  (den_mag),
    .quotient (qa)
  );

  // pressure divider operands: a large b7 is divided first and doubled after
  logic [31:0] dvd_b, qb;
  bsc_pkg::ctx_b_t ctx_b_in;
  always_comb begin
    dvd_b        = s9_b7[31] ? s9_b7 : {s9_b7[30:0], 1'b0};
    ctx_b_in.t   = s9_t;
    ctx_b_in.sel = s9_b7[31];
    ctx_b_in.err = s9_err || (s9_b4 == 32'd0);
  end

  bsc_div u_div_p (
    .clk      (clk),
    .en       (en),
    .dividend (dvd_b),
    .divisor  (s9_b4),
    .quotient (qb)
  );

  // combinational terms
  logic [31:0] qa_s, sq_c, x3_c, b3_s, b3_sh, b3_v, x3b_c, tail;
  always_comb begin
    qa_s  = ctx_a[N-1].neg ? 32'(-qa) : qa;
    sq_c  = bsc_pkg::asr32(s5_sq, 12);
    x3_c  = bsc_pkg::asr32(s6_p1, 11) + s6_x2;
    b3_s  = {coef.ac1[29:0], 2'b00} + x3_c;
    b3_sh = b3_s << coef.oss;
    b3_v  = b3_sh + 32'd2;
    x3b_c = bsc_pkg::asr32(bsc_pkg::asr32(s6_p2, 16) + s6_x1 + 32'd2, 2);
    tail  = bsc_pkg::asr32(bsc_pkg::asr32(s13_m3, 16) + s13_x2 + bsc_pkg::P_C3, 4);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0; v5 <= 1'b0; v6 <= 1'b0;
      v7 <= 1'b0; v8 <= 1'b0; v9 <= 1'b0; v11 <= 1'b0; v12 <= 1'b0; v13 <= 1'b0;
      va <= '0;
      vb <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1  <= q_valid;
      v2  <= v1;
      va  <= {va[N-2:0], v2};
      v3  <= va[N-1];
      v4  <= v3;
      v5  <= v4;
      v6  <= v5;
      v7  <= v6;
      v8  <= v7;
      v9  <= v8;
      vb  <= {vb[N-2:0], v9};
      v11 <= vb[N-1];
      v12 <= v11;
      v13 <= v12;
      out_valid <= v13;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_m   <= bsc_pkg::mul32(q_item.diff, coef.ac5);
      s1_up  <= q_item.up;

      s2_x1  <= bsc_pkg::asr32(s1_m, 15);
      s2_den <= bsc_pkg::asr32(s1_m, 15) + coef.md;
      s2_num <= {coef.mc[20:0], 11'd0};
      s2_up  <= s1_up;

      ctx_a[0] <= ctx_a_in;
      for (int i = 1; i < N; i++) ctx_a[i] <= ctx_a[i-1];

      s3_b5  <= ctx_a[N-1].x1 + qa_s;
      s3_ctx <= ctx_a[N-1];

      s4_t   <= bsc_pkg::asr32(s3_b5 + bsc_pkg::T_ROUND, 4);
      s4_b6  <= s3_b5 - bsc_pkg::T_OFFSET;
      s4_up  <= s3_ctx.up;
      s4_err <= s3_ctx.err;

      s5_sq  <= bsc_pkg::mul32(s4_b6, s4_b6);
      s5_m2  <= bsc_pkg::mul32(coef.ac2, s4_b6);
      s5_m3  <= bsc_pkg::mul32(coef.ac3, s4_b6);
      s5_t   <= s4_t;
      s5_up  <= s4_up;
      s5_err <= s4_err;

      s6_p1  <= bsc_pkg::mul32(coef.b2, sq_c);
      s6_p2  <= bsc_pkg::mul32(coef.b1, sq_c);
      s6_x2  <= bsc_pkg::asr32(s5_m2, 11);
      s6_x1  <= bsc_pkg::asr32(s5_m3, 13);
      s6_t   <= s5_t;
      s6_up  <= s5_up;
      s6_err <= s5_err;

      // division by four that truncates toward zero
      s7_b3  <= bsc_pkg::asr32(b3_v + (b3_v[31] ? 32'd3 : 32'd0), 2);
      s7_x3  <= x3b_c;
      s7_t   <= s6_t;
      s7_up  <= s6_up;
      s7_err <= s6_err;

      s8_b4m <= bsc_pkg::mul32(coef.ac4, s7_x3 + bsc_pkg::B4_BIAS);
      s8_bu  <= {13'd0, s7_up} - s7_b3;
      s8_t   <= s7_t;
      s8_err <= s7_err;

      s9_b4  <= s8_b4m >> 15;
      s9_b7  <= bsc_pkg::mul32(s8_bu, bsc_pkg::B7_SCALE >> coef.oss);
      s9_t   <= s8_t;
      s9_err <= s8_err;

      ctx_b[0] <= ctx_b_in;
      for (int i = 1; i < N; i++) ctx_b[i] <= ctx_b[i-1];

      s11_p   <= ctx_b[N-1].sel ? {qb[30:0], 1'b0} : qb;
      s11_ctx <= ctx_b[N-1];

      s12_p   <= s11_p;
      s12_m1  <= bsc_pkg::mul32(bsc_pkg::asr32(s11_p, 8), bsc_pkg::asr32(s11_p, 8));
      s12_m2  <= bsc_pkg::mul32(bsc_pkg::P_C2, s11_p);
      s12_t   <= s11_ctx.t;
      s12_err <= s11_ctx.err;

      s13_p   <= s12_p;
      s13_m3  <= bsc_pkg::mul32(s12_m1, bsc_pkg::P_C1);
      s13_x2  <= bsc_pkg::asr32(s12_m2, 16);
      s13_t   <= s12_t;
      s13_err <= s12_err;

      temperature  <= s13_err ? 32'd0 : s13_t;
      pressure     <= s13_err ? 32'd0 : s13_p + tail;
      divide_error <= s13_err;
    end
  end

endmodule

FILE: design/barometric_sensor_compensation.sv
// Throughput: one item per cycle while the output is not stalled; two 32-stage dividers,
// one quotient bit per stage, set the depth of the pipeline.
// A two-item queue parts the input from the stalling back pipeline.
// Synchronous reset clears the queue, all valid bits and the configuration to zero.
module barometric_sensor_compensation (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] raw_temperature,
  input  logic [18:0] raw_pressure,
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [31:0] temperature,
  output logic signed [31:0] pressure,
  output logic        divide_error
);

  logic [63:0] coef_a;
  logic [63:0] coef_b;
  logic [31:0] coef_c;
  logic [1:0]  oss;
  bsc_pkg::coef_t       coef;
  logic                 q_valid;
  logic                 q_take;
  bsc_pkg::front_item_t q_item;
  logic [31:0]          t_out;
  logic [31:0]          p_out;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_a <= '0;
      coef_b <= '0;
      coef_c <= '0;
      oss    <= '0;
    end else if (cfg_valid) begin
      unique case (bsc_pkg::cfg_index_t'(cfg_index))
        bsc_pkg::CFG_COEF_A: coef_a <= cfg_data;
        bsc_pkg::CFG_COEF_B: coef_b <= cfg_data;
        bsc_pkg::CFG_COEF_C: coef_c <= cfg_data[31:0];
        bsc_pkg::CFG_OSS:    oss    <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    coef.ac1 = bsc_pkg::sext16(coef_a[15:0]);
    coef.ac2 = bsc_pkg::sext16(coef_a[31:16]);
    coef.ac3 = bsc_pkg::sext16(coef_a[47:32]);
    coef.ac4 = {16'd0, coef_a[63:48]};
    coef.ac5 = {16'd0, coef_b[15:0]};
    coef.ac6 = {16'd0, coef_b[31:16]};
    coef.b1  = bsc_pkg::sext16(coef_b[47:32]);
    coef.b2  = bsc_pkg::sext16(coef_b[63:48]);
    coef.mc  = bsc_pkg::sext16(coef_c[15:0]);
    coef.md  = bsc_pkg::sext16(coef_c[31:16]);
    coef.oss = oss;
  end

  bsc_front u_front (
    .clk             (clk),
    .rst             (rst),
    .coef            (coef),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .raw_temperature (raw_temperature),
    .raw_pressure    (raw_pressure),
    .q_valid         (q_valid),
    .q_take          (q_take),
    .q_item          (q_item)
  );

  bsc_back u_back (
    .clk          (clk),
    .rst          (rst),
    .coef         (coef),
    .q_valid      (q_valid),
    .q_take       (q_take),
    .q_item       (q_item),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .temperature  (t_out),
    .pressure     (p_out),
    .divide_error (divide_error)
  );

  assign temperature = $signed(t_out);
  assign pressure    = $signed(p_out);

endmodule

FILE: design/bsc_checker.sv
// Port-level checks for the compensation block, bound to the top level.
module bsc_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] temperature,
  input logic [31:0] pressure,
  input logic        divide_error
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(temperature) && $stable(pressure))
    else $error("stalled result item changed");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && divide_error |-> temperature == 32'd0 && pressure == 32'd0)
    else $error("error item carries non-zero results");

  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result item shown after reset");

endmodule

bind barometric_sensor_compensation bsc_checker u_bsc_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .temperature  (temperature),
  .pressure     (pressure),
  .divide_error (divide_error)
);

FILE: dv/barometric_sensor_compensation_tb.sv
// Testbench for the barometric compensation block: directed and random items checked against a predictor.
module barometric_sensor_compensation_tb;

  typedef struct {
    logic [15:0] ut;
    logic [18:0] up;
  } raw_item_t;

  typedef struct {
    logic [31:0] t;
    logic [31:0] p;
    logic        err;
  } comp_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [15:0] raw_temperature = '0;
  logic [18:0] raw_pressure = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic signed [31:0] temperature;
  logic signed [31:0] pressure;
  logic        divide_error;

  barometric_sensor_compensation u_dut (.*);

  logic [63:0] coef_a = '0, coef_b = '0;
  logic [31:0] coef_c = '0;
  logic [1:0]  oss_mode = '0;

  raw_item_t    raw_queue[$];
  comp_result_t expected_results[$];
  int unsigned  mismatches = 0;
  int unsigned  cycle_count = 0;
  bit           driver_hold = 1'b0;
  bit           in_taken = 1'b0;
  int unsigned  burst_left = 0, gap_left = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [31:0] sra(input logic [31:0] a, input int n);
    return 32'($signed(a) >>> n);
  endfunction

  function automatic logic [31:0] sdiv(input logic [31:0] a, input logic [31:0] b);
    longint q;
    q = longint'($signed(a)) / longint'($signed(b));
    return q[31:0];
  endfunction

  function automatic logic [31:0] sx(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic comp_result_t compensate(input raw_item_t it);
    comp_result_t r;
    logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
    logic [31:0] x1, x2, x3, den, b3, b4, b5, b6, b7, sq, p, p8;
    ac1 = sx(coef_a[15:0]);  ac2 = sx(coef_a[31:16]);
    ac3 = sx(coef_a[47:32]); ac4 = {16'd0, coef_a[63:48]};
    ac5 = {16'd0, coef_b[15:0]}; ac6 = {16'd0, coef_b[31:16]};
    b1 = sx(coef_b[47:32]); b2 = sx(coef_b[63:48]);
    mc = sx(coef_c[15:0]);  md = sx(coef_c[31:16]);
    r = '{t: '0, p: '0, err: 1'b1};
    x1 = sra(({16'd0, it.ut} - ac6) * ac5, 15);
    den = x1 + md;
    if (den == 0) return r;
    x2 = sdiv(mc << 11, den);
    b5 = x1 + x2;
    r.t = sra(b5 + 32'd8, 4);
    b6 = b5 - 32'd4000;
    sq = sra(b6 * b6, 12);
    x3 = sra(b2 * sq, 11) + sra(ac2 * b6, 11);
    b3 = sdiv((((ac1 * 32'd4) + x3) << oss_mode) + 32'd2, 32'd4);
    x1 = sra(ac3 * b6, 13);
    x2 = sra(b1 * sq, 16);
    x3 = sra(x1 + x2 + 32'd2, 2);
    b4 = (ac4 * (x3 + 32'd32768)) >> 15;
    if (b4 == 0) begin
      r.t = '0;
      return r;
    end
    b7 = ({13'd0, it.up} - b3) * (32'd50000 >> oss_mode);
    if (!b7[31]) p = (b7 * 32'd2) / b4;
    else p = (b7 / b4) * 32'd2;
    p8 = sra(p, 8);
    x1 = sra((p8 * p8) * 32'd3038, 16);
    x2 = sra(32'hFFFF_E343 * p, 16);
    r.p = p + sra(x1 + x2 + 32'd3791, 4);
    r.err = 1'b0;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch on %s: got %h, expected %h", what, got, want);
    mismatches++;
  endtask

  // Driver: bursts and gaps; valid holds until the item is taken.
  always @(negedge clk) begin
    if (!rst) begin
      if (in_taken) void'(raw_queue.pop_front());
      if (!in_valid || in_taken) begin
        if (gap_left > 0) gap_left--;
        if (raw_queue.size() > 0 && !driver_hold && gap_left == 0) begin
          in_valid <= 1'b1;
          raw_temperature <= raw_queue[0].ut;
          raw_pressure <= raw_queue[0].up;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else burst_left--;
        end else in_valid <= 1'b0;
      end
      case (cycle_count % 64 < 20 ? 0 : $urandom_range(0, 3))
        0: out_ready <= 1'b1;
        default: out_ready <= ((cycle_count / 7) % 3 != 0);
      endcase
    end
  end

  // Monitor: input items are predicted at the edge that accepts them.
  always @(posedge clk) begin
    comp_result_t want;
    cycle_count++;
    in_taken = 1'b0;
    if (!rst && in_valid && in_ready) begin
      expected_results.push_back(compensate('{raw_temperature, raw_pressure}));
      in_taken = 1'b1;
    end
    if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result item", temperature, 32'd0);
      end else begin
        want = expected_results.pop_front();
        if (temperature !== want.t) report_mismatch("temperature", temperature, want.t);
        if (pressure !== want.p) report_mismatch("pressure", pressure, want.p);
        if (divide_error !== want.err)
          report_mismatch("divide_error", {31'd0, divide_error}, {31'd0, want.err});
      end
    end
    if (cycle_count > 600000) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic write_reg(input bsc_pkg::cfg_index_t idx, input logic [63:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      bsc_pkg::CFG_COEF_A: coef_a = val;
      bsc_pkg::CFG_COEF_B: coef_b = val;
      bsc_pkg::CFG_COEF_C: coef_c = val[31:0];
      bsc_pkg::CFG_OSS:    oss_mode = val[1:0];
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    while (raw_queue.size() > 0 || in_valid || expected_results.size() > 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  function automatic raw_item_t random_item();
    raw_item_t it;
    it.ut = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(20000, 36000));
    it.up = $urandom_range(0, 3) == 0 ? 19'($urandom) : 19'($urandom_range(20000, 160000));
    return it;
  endfunction

  initial begin
    logic [63:0] realistic_a, realistic_b;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    // Directed: all-zero coefficients give a zero temperature divisor.
    raw_queue.push_back('{16'h0000, 19'h00000});
    raw_queue.push_back('{16'hFFFF, 19'h7FFFF});
    drain();
    realistic_a = {16'd32741, 16'hFFC4, 16'hFB9D, 16'd408};
    realistic_b = {16'd4, 16'd6190, 16'd18755, 16'd32757};
    write_reg(bsc_pkg::CFG_COEF_A, realistic_a);
    write_reg(bsc_pkg::CFG_COEF_B, realistic_b);
    write_reg(bsc_pkg::CFG_COEF_C, 64'({16'd2868, 16'hD4BD}));
    for (int m = 0; m < 4; m++) begin
      write_reg(bsc_pkg::CFG_OSS, 64'(m));
      raw_queue.push_back('{16'd27898, 19'd23843});
      raw_queue.push_back('{16'h0000, 19'h00000});
      raw_queue.push_back('{16'hFFFF, 19'h7FFFF});
      raw_queue.push_back('{16'h5555, 19'h2AAAA});
      drain();
    end
    // Zero b4: ac4 of zero with valid temperature path.
    write_reg(bsc_pkg::CFG_COEF_A, {16'd0, realistic_a[47:0]});
    raw_queue.push_back('{16'd27898, 19'd23843});
    drain();
    // md of zero and ut equal to ac6 hits the temperature divisor.
    write_reg(bsc_pkg::CFG_COEF_A, realistic_a);
    write_reg(bsc_pkg::CFG_COEF_C, 64'({16'd0, 16'hD4BD}));
    raw_queue.push_back('{16'd18755, 19'd1000});
    drain();
    write_reg(bsc_pkg::CFG_COEF_C, 64'({16'd2868, 16'hD4BD}));
    // Random phases with realistic and fully random coefficients.
    for (int ph = 0; ph < 8; ph++) begin
      if (ph % 2 == 1) begin
        write_reg(bsc_pkg::CFG_COEF_A, {$urandom, $urandom});
        write_reg(bsc_pkg::CFG_COEF_B, {$urandom, $urandom});
        write_reg(bsc_pkg::CFG_COEF_C, 64'($urandom));
      end else begin
        write_reg(bsc_pkg::CFG_COEF_A, realistic_a ^ 64'($urandom_range(0, 255)));
        write_reg(bsc_pkg::CFG_COEF_B, realistic_b);
        write_reg(bsc_pkg::CFG_COEF_C, 64'({16'd2868, 16'hD4BD}));
      end
      write_reg(bsc_pkg::CFG_OSS, 64'(ph % 4));
      for (int i = 0; i < 250; i++) raw_queue.push_back(random_item());
      if (ph == 3) begin
        while (raw_queue.size() > 120) @(posedge clk);
        driver_hold = 1'b1;
        while (in_valid || expected_results.size() > 0) @(posedge clk);
        driver_hold = 1'b0;
      end
      drain();
    end
    if (mismatches == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end
endmodule
